// ===== hdl/vnl_pkg.sv =====
// ----------------------------------------------------------------------------
// vnl_pkg
// Shared constants and types for the neighbour list builder.
// ----------------------------------------------------------------------------
package vnl_pkg;

  localparam int unsigned MaxParticles = 64;
  localparam int unsigned CoordBits    = 24;
  localparam int unsigned AddrBits     = $clog2(MaxParticles);
  localparam int unsigned CountBits    = 7;
  localparam int unsigned RegBits      = 23;
  localparam int unsigned PosWidth     = 3 * CoordBits;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpCheck = 2'd1,
    OpScan  = 2'd2,
    OpSave  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegCut   = 2'd0,
    RegBoxX  = 2'd1,
    RegBoxZ  = 2'd2,
    RegCount = 2'd3
  } reg_e;

  // one distance job handed to the datapath
  typedef struct packed {
    logic                 valid;
    logic                 is_check;
    logic [AddrBits-1:0]  m;
    logic                 last;
  } job_t;

  // folded magnitude along one axis, saturated to 2^24
  function automatic logic [24:0] fold_mag(input logic signed [CoordBits-1:0] a,
                                           input logic signed [CoordBits-1:0] b,
                                           input logic [RegBits-1:0] box,
                                           input logic periodic);
    logic signed [CoordBits+1:0] d;
    logic signed [CoordBits+1:0] f;
    logic signed [CoordBits+2:0] d2;
    logic signed [CoordBits+2:0] bx;
    logic [CoordBits+1:0]        u;
    begin
      d  = (CoordBits+2)'(a) - (CoordBits+2)'(b);
      d2 = (CoordBits+3)'(d) <<< 1;
      bx = (CoordBits+3)'({1'b0, box});
      f  = d;
      if (periodic) begin
        if (d2 >= bx) f = d - (CoordBits+2)'(bx);
        else if (d2 <= -bx) f = d + (CoordBits+2)'(bx);
      end
      u = f[CoordBits+1] ? (CoordBits+2)'(-f) : (CoordBits+2)'(f);
      fold_mag = (u > (CoordBits+2)'(25'h1000000)) ? 25'h1000000 : u[24:0];
    end
  endfunction

endpackage

// ===== hdl/vnl_ram.sv =====
// ----------------------------------------------------------------------------
// vnl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vnl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/vnl_dist.sv =====
// ----------------------------------------------------------------------------
// vnl_dist
// Distance pipeline: fold, square, sum and compare for one pair per cycle.
// ----------------------------------------------------------------------------
module vnl_dist (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  vnl_pkg::job_t                        job_i,
  input  logic [vnl_pkg::PosWidth-1:0]         pos_a_i,
  input  logic [vnl_pkg::PosWidth-1:0]         pos_b_i,
  input  logic [vnl_pkg::RegBits-1:0]          cut_i,
  input  logic [vnl_pkg::RegBits-1:0]          box_x_i,
  input  logic [vnl_pkg::RegBits-1:0]          box_z_i,
  output vnl_pkg::job_t                        job_o,
  output logic                                 hit_o,
  output logic [49:0]                          d2_o
);

  localparam int unsigned Cb = vnl_pkg::CoordBits;

  vnl_pkg::job_t j1_q, j2_q;
  logic [24:0]   ax_q, ay_q, az_q;
  logic          near_q;
  logic [49:0]   sx_q, sy_q, sz_q;
  logic          near2_q;
  logic [25:0]   lim;
  logic [24:0]   ax_d, ay_d, az_d;
  logic [51:0]   d2;
  logic [63:0]   rc36;

  always_comb begin
    ax_d = vnl_pkg::fold_mag(pos_b_i[3*Cb-1:2*Cb], pos_a_i[3*Cb-1:2*Cb], box_x_i, 1'b1);
    ay_d = vnl_pkg::fold_mag(pos_b_i[2*Cb-1:Cb], pos_a_i[2*Cb-1:Cb], box_x_i, 1'b0);
    az_d = vnl_pkg::fold_mag(pos_b_i[Cb-1:0], pos_a_i[Cb-1:0], box_z_i, 1'b1);
    lim  = 26'(cut_i) * 26'd6;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j1_q <= '0;
      j2_q <= '0;
    end else begin
      j1_q <= job_i;
      j2_q <= j1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    // per-axis box test before the squares
    near_q  <= (28'(ax_d) * 28'd5 < 28'(lim)) && (28'(ay_d) * 28'd5 < 28'(lim))
               && (28'(az_d) * 28'd5 < 28'(lim));
    sx_q    <= 50'(ax_q) * 50'(ax_q);
    sy_q    <= 50'(ay_q) * 50'(ay_q);
    sz_q    <= 50'(az_q) * 50'(az_q);
    near2_q <= near_q;
  end

  always_comb begin
    d2    = 52'(sx_q) + 52'(sy_q) + 52'(sz_q);
    rc36  = 64'(cut_i) * 64'(cut_i) * 64'd36;
    job_o = j2_q;
    hit_o = near2_q && ((64'(d2) * 64'd25) < rc36);
    d2_o  = d2[49:0];
  end

endmodule

// ===== hdl/verlet_neighbor_list_builder.sv =====
// ----------------------------------------------------------------------------
// verlet_neighbor_list_builder
// Verlet neighbour list builder over a 64-slot position store.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | in        | in_valid_i / in_ready_o, operation_i .. first_call_i
// out     | out       | out_valid_o / out_ready_i, pair_first_o .. last_o
// cfg     | in        | cfg_we_i, cfg_index_i, cfg_data_i
//
// load, forced check and a scan past the count skip the walk; snapshot copies the slots
// below the count, check walks them all, scan of row n those above n; one slot a cycle is
// read from the position memories into the 3-deep distance pipe; a scan waits for fifo room.
// no clearing pass after reset; the stores hold garbage until written.
// in_ready returns as soon as the final word sits in the output register.
// a stalled output word holds the scan walk once the 8-entry pair fifo has no room left.
module verlet_neighbor_list_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  index_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic        first_call_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pair_first_o,
  output logic [5:0]  pair_second_o,
  output logic        pair_valid_o,
  output logic        rebuild_needed_o,
  output logic        last_o
);

  localparam int unsigned Aw = vnl_pkg::AddrBits;
  localparam int unsigned Pw = vnl_pkg::PosWidth;
  localparam int unsigned Cw = vnl_pkg::CountBits;
  localparam int unsigned Rw = vnl_pkg::RegBits;

  typedef enum logic [2:0] {
    StIdle, StRow, StWalk, StDrain, StSave, StOut
  } state_e;

  state_e                  state_q, state_d;
  logic [Rw-1:0]           cut_q, box_x_q, box_z_q;
  logic [Cw-1:0]           count_q;
  vnl_pkg::op_e            op_q, op_d;
  logic [Aw-1:0]           row_q, row_d;
  logic [Cw-1:0]           ptr_q, ptr_d;
  logic [Pw-1:0]           row_pos_q, row_pos_d;
  logic [49:0]             d2max_q, d2max_d;
  logic                    found_q, found_d, first_q, first_d;
  logic                    snap_q, snap_d;
  logic [Aw-1:0]           snap_addr_q, snap_addr_d;
  logic                    in_ready_q, in_ready_d;
  logic                    out_valid_q, out_valid_d;
  logic [Aw-1:0]           pf_q, pf_d, ps_q, ps_d;
  logic                    pv_q, pv_d, rb_q, rb_d, last_q, last_d;
  logic [1:0]              fl_q, fl_d;
  logic [Aw-1:0]           hq_q [8];
  logic [2:0]              hq_wr_q, hq_wr_d, hq_rd_q, hq_rd_d;
  logic [3:0]              hq_cnt_q, hq_cnt_d;
  logic [Cw-1:0]           cnt;
  logic                    in_acc, out_acc, out_free, room, push, pop, rebuild;

  logic                    cur_we, sav_we;
  logic [Aw-1:0]           cur_raddr;
  logic [Pw-1:0]           cur_rdata, sav_rdata;
  vnl_pkg::job_t           job, job_q, job_out;
  logic                    hit;
  logic [49:0]             d2;

  assign cnt      = (count_q > Cw'(vnl_pkg::MaxParticles)) ? Cw'(vnl_pkg::MaxParticles)
                                                            : count_q;
  assign in_acc   = in_valid_i && in_ready_q;
  assign out_acc  = out_valid_q && out_ready_i;
  assign out_free = !out_valid_q || out_ready_i;
  // one fifo place stays free for every test still in the pipe
  assign room     = (5'(hq_cnt_q) + 5'(fl_q)) < 5'd8;
  assign push     = job_out.valid && !job_out.is_check && hit;
  // a pair leaves once a later one or the end of the walk tells whether it is last
  assign pop      = (op_q == vnl_pkg::OpScan) && out_free &&
                    ((hq_cnt_q > 4'd1) || (hq_cnt_q == 4'd1 && state_q == StOut));
  assign rebuild  = first_q || !((64'(d2max_q) * 64'd100) < (64'(cut_q) * 64'(cut_q)));

  assign in_ready_o       = in_ready_q;
  assign out_valid_o      = out_valid_q;
  assign pair_first_o     = pf_q;
  assign pair_second_o    = ps_q;
  assign pair_valid_o     = pv_q;
  assign rebuild_needed_o = rb_q;
  assign last_o           = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q   <= 23'd65536;
      box_x_q <= 23'd1048576;
      box_z_q <= 23'd1048576;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (vnl_pkg::reg_e'(cfg_index_i))
        vnl_pkg::RegCut:   cut_q   <= cfg_data_i;
        vnl_pkg::RegBoxX:  box_x_q <= cfg_data_i;
        vnl_pkg::RegBoxZ:  box_z_q <= cfg_data_i;
        vnl_pkg::RegCount: count_q <= cfg_data_i[Cw-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_we    = in_acc && (vnl_pkg::op_e'(operation_i) == vnl_pkg::OpLoad);
    cur_raddr = (state_q == StIdle) ? index_i : ptr_q[Aw-1:0];
    sav_we    = snap_q;
    job       = '0;
    if (state_q == StWalk && ptr_q < cnt && (op_q == vnl_pkg::OpCheck || room)) begin
      job.valid    = 1'b1;
      job.is_check = (op_q == vnl_pkg::OpCheck);
      job.m        = ptr_q[Aw-1:0];
    end
  end

  vnl_ram #(.Width(Pw), .Depth(vnl_pkg::MaxParticles)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(index_i), .wdata_i({pos_x_i, pos_y_i, pos_z_i}),
    .raddr_i(cur_raddr), .rdata_o(cur_rdata)
  );

  vnl_ram #(.Width(Pw), .Depth(vnl_pkg::MaxParticles)) u_sav (
    .clk_i, .we_i(sav_we), .waddr_i(snap_addr_q), .wdata_i(cur_rdata),
    .raddr_i(ptr_q[Aw-1:0]), .rdata_o(sav_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) job_q <= '0;
    else         job_q <= job;
  end

  // check compares current against saved; scan compares slot against row
  vnl_dist u_dist (
    .clk_i, .rst_ni,
    .job_i(job_q),
    .pos_a_i(job_q.is_check ? sav_rdata : row_pos_q),
    .pos_b_i(cur_rdata),
    .cut_i(cut_q), .box_x_i(box_x_q), .box_z_i(box_z_q),
    .job_o(job_out), .hit_o(hit), .d2_o(d2)
  );

  always_ff @(posedge clk_i) begin
    if (push) hq_q[hq_wr_q] <= job_out.m;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    row_d       = row_q;
    ptr_d       = ptr_q;
    row_pos_d   = row_pos_q;
    d2max_d     = d2max_q;
    found_d     = found_q;
    first_d     = first_q;
    snap_d      = 1'b0;
    snap_addr_d = snap_addr_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pf_d        = pf_q;
    ps_d        = ps_q;
    pv_d        = pv_q;
    rb_d        = rb_q;
    last_d      = last_q;
    fl_d        = fl_q + 2'(job.valid) - 2'(job_out.valid);
    hq_wr_d     = hq_wr_q + 3'(push);
    hq_rd_d     = hq_rd_q + 3'(pop);
    hq_cnt_d    = hq_cnt_q + 4'(push) - 4'(pop);
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          in_ready_d = 1'b0;
          op_d       = vnl_pkg::op_e'(operation_i);
          row_d      = index_i;
          first_d    = first_call_i;
          d2max_d    = '0;
          found_d    = 1'b0;
          ptr_d      = '0;
          case (vnl_pkg::op_e'(operation_i))
            vnl_pkg::OpCheck: state_d = first_call_i ? StOut : StWalk;
            vnl_pkg::OpScan: begin
              ptr_d   = Cw'(index_i) + Cw'(1);
              state_d = (Cw'(index_i) < cnt) ? StRow : StOut;
            end
            vnl_pkg::OpSave: state_d = StSave;
            default: state_d = StOut;
          endcase
        end
      end
      StRow: begin
        row_pos_d = cur_rdata;
        state_d   = StWalk;
      end
      StWalk: begin
        if (job.valid) ptr_d = ptr_q + Cw'(1);
        else if (ptr_q >= cnt) state_d = StDrain;
      end
      StDrain: begin
        if (fl_q == 2'd0) state_d = StOut;
      end
      StSave: begin
        // read slot ptr, write it in the next cycle
        if (ptr_q < cnt) begin
          ptr_d       = ptr_q + Cw'(1);
          snap_d      = 1'b1;
          snap_addr_d = ptr_q[Aw-1:0];
        end else if (!snap_q) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (op_q == vnl_pkg::OpScan && found_q) begin
          if (pop && hq_cnt_q == 4'd1) begin
            state_d    = StIdle;
            in_ready_d = 1'b1;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          pf_d        = '0;
          ps_d        = '0;
          pv_d        = 1'b0;
          rb_d        = (op_q == vnl_pkg::OpCheck) && rebuild;
          last_d      = 1'b1;
          state_d     = StIdle;
          in_ready_d  = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
    if (job_out.valid && job_out.is_check && d2 > d2max_q) d2max_d = d2;
    if (push) found_d = 1'b1;
    if (pop) begin
      out_valid_d = 1'b1;
      pf_d        = row_q;
      ps_d        = hq_q[hq_rd_q];
      pv_d        = 1'b1;
      rb_d        = 1'b0;
      last_d      = (hq_cnt_q == 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= vnl_pkg::OpLoad;
      row_q       <= '0;
      ptr_q       <= '0;
      row_pos_q   <= '0;
      d2max_q     <= '0;
      found_q     <= 1'b0;
      first_q     <= 1'b0;
      snap_q      <= 1'b0;
      snap_addr_q <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      pf_q        <= '0;
      ps_q        <= '0;
      pv_q        <= 1'b0;
      rb_q        <= 1'b0;
      last_q      <= 1'b0;
      fl_q        <= '0;
      hq_wr_q     <= '0;
      hq_rd_q     <= '0;
      hq_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      row_q       <= row_d;
      ptr_q       <= ptr_d;
      row_pos_q   <= row_pos_d;
      d2max_q     <= d2max_d;
      found_q     <= found_d;
      first_q     <= first_d;
      snap_q      <= snap_d;
      snap_addr_q <= snap_addr_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
      pf_q        <= pf_d;
      ps_q        <= ps_d;
      pv_q        <= pv_d;
      rb_q        <= rb_d;
      last_q      <= last_d;
      fl_q        <= fl_d;
      hq_wr_q     <= hq_wr_d;
      hq_rd_q     <= hq_rd_d;
      hq_cnt_q    <= hq_cnt_d;
    end
  end

endmodule
